### src/fnpll_pkg.sv
`timescale 1ns / 1ps

package fnpll_pkg;

    // field widths
    localparam int LO_W   = 33;
    localparam int REF_W  = 27;
    localparam int VCO_W  = 40;
    localparam int DEN_W  = 29;
    localparam int EXP_W  = 3;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LO_MAX = 2'd1;

    // reset values of the registers
    localparam logic [REF_W-1:0] REF_RESET    = 27'd26000000;
    localparam logic [LO_W-1:0]  LO_MAX_RESET = 33'd5400000000;

    // VCO above this uses feedback divide by four
    localparam logic [VCO_W-1:0] VCO_SPLIT_HZ = 40'd3200000000;
    localparam int EXP_MAX = 7;

    // output codes
    localparam logic [1:0] FBK_DIV4 = 2'd2;
    localparam logic [1:0] FBK_DIV2 = 2'd1;
    localparam logic [1:0] LF_DIV4  = 2'd3;
    localparam logic [1:0] LF_DIV2  = 2'd2;

    // one classified request on its way to the divider
    typedef struct packed {
        logic [VCO_W-1:0] vco;
        logic [DEN_W-1:0] denom;
        logic [EXP_W-1:0] lo_div_exp;
        logic             fbk4;
        logic             err;
    } fnpll_job_t;

endpackage

### src/fnpll_front.sv
`timescale 1ns / 1ps

module fnpll_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fnpll_pkg::LO_W-1:0]       lo_req_hz,
    input  logic [fnpll_pkg::REF_W-1:0]      ref_freq,
    input  logic [fnpll_pkg::LO_W-1:0]       lo_max,
    output logic                             job_valid,
    input  logic                             job_ready,
    output fnpll_pkg::fnpll_job_t            job
);

    logic                            valid_reg, valid_next;
    logic [fnpll_pkg::LO_W-1:0]      lo_reg;
    logic [fnpll_pkg::EXP_W-1:0]     exp_reg, exp_c;
    logic                            err_reg, err_c;
    logic [fnpll_pkg::VCO_W-1:0]     vco_c;
    logic [fnpll_pkg::DEN_W-1:0]     den_c;
    logic                            fbk4_c;
    logic                            ovf_c;

    assign in_ready = !valid_reg || job_ready;

    // exponent: largest k up to the limit with lo * 2^k not above lo_max
    always_comb
    begin
        exp_c = '0;
        for (int k = 1; k <= fnpll_pkg::EXP_MAX; k++)
        begin
            if ((fnpll_pkg::VCO_W'(lo_req_hz) << k) <= fnpll_pkg::VCO_W'(lo_max))
                exp_c = fnpll_pkg::EXP_W'(k);
        end
        err_c = (lo_req_hz == '0) || (lo_req_hz > lo_max) || (ref_freq == '0);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lo_reg  <= lo_req_hz;
            exp_reg <= exp_c;
            err_reg <= err_c;
        end
    end

    // VCO, feedback divider and integer overflow from the held word
    always_comb
    begin
        vco_c  = fnpll_pkg::VCO_W'(lo_reg) << exp_reg;
        fbk4_c = vco_c > fnpll_pkg::VCO_SPLIT_HZ;
        den_c  = fbk4_c ? (fnpll_pkg::DEN_W'(ref_freq) << 2)
                        : (fnpll_pkg::DEN_W'(ref_freq) << 1);
        ovf_c  = vco_c >= fnpll_pkg::VCO_W'({den_c, 8'd0});
    end

    assign job_valid      = valid_reg;
    assign job.vco        = vco_c;
    assign job.denom      = den_c;
    assign job.lo_div_exp = exp_reg;
    assign job.fbk4       = fbk4_c;
    assign job.err        = err_reg || ovf_c;

endmodule

### src/fnpll_queue.sv
`timescale 1ns / 1ps

module fnpll_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  fnpll_pkg::fnpll_job_t push_job,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output fnpll_pkg::fnpll_job_t pop_job
);

    fnpll_pkg::fnpll_job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_job = mem[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

### src/fnpll_back.sv
`timescale 1ns / 1ps

module fnpll_back
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  fnpll_pkg::fnpll_job_t job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            n_integer,
    output logic [2:0]            lo_div_exp,
    output logic [1:0]            fbk_code,
    output logic [1:0]            loop_filter_code,
    output logic [23:0]           frac_word,
    output logic [32:0]           tuned_freq_hz,
    output logic                  range_error
);

    localparam int NST = 4;
    localparam int SPS = (8 + FRAC_BITS + NST - 1) / NST;
    localparam int S   = NST * SPS;
    localparam int DW  = fnpll_pkg::DEN_W;

    logic                  adv;
    logic                  dv_reg [NST];
    logic [DW-1:0]         rem_reg [NST];
    logic [S-1:0]          acc_reg [NST];
    fnpll_pkg::fnpll_job_t meta_reg [NST];
    logic [DW-1:0]         rem_next [NST];
    logic [S-1:0]          acc_next [NST];

    logic                  mv_reg;
    logic [31:0]           m_reg, m_next;
    logic [60:0]           prod_reg, prod_next;
    fnpll_pkg::fnpll_job_t mmeta_reg;

    logic                  ov_reg;
    logic [32:0]           tuned_next;

    // whole back pipeline moves when the output word is free or taken
    assign adv       = !ov_reg || out_ready;
    assign job_ready = adv;

    // restoring divider, SPS quotient bits per stage
    for (genvar i = 0; i < NST; i++)
    begin : g_div
        logic [fnpll_pkg::VCO_W+FRAC_BITS-1:0] dvd;
        logic [DW-1:0] r_in;
        logic [S-1:0]  a_in;
        logic [DW-1:0] den;
        logic [DW:0]   t;

        always_comb
        begin
            dvd = {job.vco, {FRAC_BITS{1'b0}}};
            if (i == 0)
            begin
                r_in = dvd[S+DW-1:S];
                a_in = dvd[S-1:0];
                den  = job.denom;
            end
            else
            begin
                r_in = rem_reg[(i > 0) ? i - 1 : 0];
                a_in = acc_reg[(i > 0) ? i - 1 : 0];
                den  = meta_reg[(i > 0) ? i - 1 : 0].denom;
            end
            t = '0;
            for (int s = 0; s < SPS; s++)
            begin
                t    = {r_in, a_in[S-1]};
                a_in = {a_in[S-2:0], 1'b0};
                if (t >= {1'b0, den})
                begin
                    r_in    = DW'(t - {1'b0, den});
                    a_in[0] = 1'b1;
                end
                else
                begin
                    r_in = t[DW-1:0];
                end
            end
            rem_next[i] = r_in;
            acc_next[i] = a_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[i] <= 1'b0;
            else if (adv)
                dv_reg[i] <= (i == 0) ? job_valid : dv_reg[(i > 0) ? i - 1 : 0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next[i];
                acc_reg[i]  <= acc_next[i];
                meta_reg[i] <= (i == 0) ? job : meta_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // ratio aligned to 24 fraction bits, then times the divisor
    always_comb
    begin
        m_next    = 32'(acc_reg[NST-1][FRAC_BITS+7:0]) << (24 - FRAC_BITS);
        prod_next = 61'(meta_reg[NST-1].denom) * 61'(m_next);
    end

    // achieved frequency back at the LO side
    assign tuned_next = 33'(prod_reg >> (24 + 32'(mmeta_reg.lo_div_exp)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg <= dv_reg[NST-1];
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg     <= m_next;
            prod_reg  <= prod_next;
            mmeta_reg <= meta_reg[NST-1];
            if (mmeta_reg.err)
            begin
                n_integer        <= '0;
                lo_div_exp       <= '0;
                fbk_code         <= '0;
                loop_filter_code <= '0;
                frac_word        <= '0;
                tuned_freq_hz    <= '0;
                range_error      <= 1'b1;
            end
            else
            begin
                n_integer        <= m_reg[31:24];
                lo_div_exp       <= mmeta_reg.lo_div_exp;
                fbk_code         <= mmeta_reg.fbk4 ? fnpll_pkg::FBK_DIV4 : fnpll_pkg::FBK_DIV2;
                loop_filter_code <= mmeta_reg.fbk4 ? fnpll_pkg::LF_DIV4 : fnpll_pkg::LF_DIV2;
                frac_word        <= m_reg[23:0];
                tuned_freq_hz    <= tuned_next;
                range_error      <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |->
            (n_integer == '0 && frac_word == '0 && tuned_freq_hz == '0 && fbk_code == '0))
        else $error("error word carries nonzero fields");

    a_codes_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !range_error) |->
            ((fbk_code == fnpll_pkg::FBK_DIV4 && loop_filter_code == fnpll_pkg::LF_DIV4) ||
             (fbk_code == fnpll_pkg::FBK_DIV2 && loop_filter_code == fnpll_pkg::LF_DIV2)))
        else $error("feedback and loop filter codes disagree");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(tuned_freq_hz)))
        else $error("stalled result word lost");

    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !job_ready)
        else $error("queue popped while output stalled");
`endif

endmodule

### src/frac_n_pll_divider_calc_core.sv
`timescale 1ns / 1ps
// Path from input accept to result valid: front register, two-word queue,
// four divider stages, multiply stage, output register.
// Throughput: one word per cycle while out_ready does not stall the output;
// the divider is four pipelined stages of restoring steps, followed by one multiply stage and the output register.
// Reset (rst_n, asynchronous, active low) empties all stages and the queue
// and loads the reference and LO maximum registers with their defaults.
module frac_n_pll_divider_calc_core
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [32:0] lo_req_hz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  n_integer,
    output logic [2:0]  lo_div_exp,
    output logic [1:0]  fbk_code,
    output logic [1:0]  loop_filter_code,
    output logic [23:0] frac_word,
    output logic [32:0] tuned_freq_hz,
    output logic        range_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [32:0] cfg_data
);

    logic [fnpll_pkg::REF_W-1:0] ref_reg;
    logic [fnpll_pkg::LO_W-1:0]  lo_max_reg;
    logic                        f_valid, f_ready;
    fnpll_pkg::fnpll_job_t       f_job;
    logic                        q_valid, q_ready;
    fnpll_pkg::fnpll_job_t       q_job;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg    <= fnpll_pkg::REF_RESET;
            lo_max_reg <= fnpll_pkg::LO_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fnpll_pkg::CFG_REF:    ref_reg    <= cfg_data[fnpll_pkg::REF_W-1:0];
                fnpll_pkg::CFG_LO_MAX: lo_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fnpll_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .lo_req_hz  (lo_req_hz),
        .ref_freq   (ref_reg),
        .lo_max     (lo_max_reg),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    fnpll_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    fnpll_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (q_valid),
        .job_ready        (q_ready),
        .job              (q_job),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .n_integer        (n_integer),
        .lo_div_exp       (lo_div_exp),
        .fbk_code         (fbk_code),
        .loop_filter_code (loop_filter_code),
        .frac_word        (frac_word),
        .tuned_freq_hz    (tuned_freq_hz),
        .range_error      (range_error)
    );

endmodule

### dv/fnpll_checker.sv
`timescale 1ns / 1ps

module fnpll_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [32:0] lo_req_hz,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  n_integer,
    input  logic [2:0]  lo_div_exp,
    input  logic [1:0]  fbk_code,
    input  logic [1:0]  loop_filter_code,
    input  logic [23:0] frac_word,
    input  logic [32:0] tuned_freq_hz,
    input  logic        range_error,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [32:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int FRAC_W = 24;

    typedef struct {
        logic [7:0]  n_int;
        logic [2:0]  div_exp;
        logic [1:0]  fbk;
        logic [1:0]  lf;
        logic [23:0] frac;
        logic [32:0] tuned;
        logic        err;
    } synth_word_t;

    logic [fnpll_pkg::REF_W-1:0] ref_hz;
    logic [fnpll_pkg::LO_W-1:0]  lo_max;
    synth_word_t                 settings_q[$];

    assign pending = settings_q.size();

    // divider settings for one requested LO frequency
    function automatic synth_word_t calc_settings(logic [32:0] lo);
        synth_word_t r;
        logic [63:0] quot, vco, den, n, rem, fr, tn;
        int e;
        r = '{default: '0};
        e = 0;
        if (lo == 0 || lo > lo_max || ref_hz == 0)
        begin
            r.err = 1'b1;
            return r;
        end
        quot = 64'(lo_max) / 64'(lo);
        while (e < fnpll_pkg::EXP_MAX && (quot >> (e + 1)) != 0)
            e++;
        vco = 64'(lo) << e;
        den = (vco > 64'(fnpll_pkg::VCO_SPLIT_HZ)) ? 64'(ref_hz) * 4 : 64'(ref_hz) * 2;
        n   = vco / den;
        rem = vco % den;
        if (n > 255)
        begin
            r.err = 1'b1;
            return r;
        end
        fr = (rem << FRAC_W) / den;
        tn = (den * ((n << 24) + fr)) >> (24 + e);
        r.n_int   = n[7:0];
        r.div_exp = e[2:0];
        r.fbk     = (vco > 64'(fnpll_pkg::VCO_SPLIT_HZ)) ? fnpll_pkg::FBK_DIV4
                                                         : fnpll_pkg::FBK_DIV2;
        r.lf      = (vco > 64'(fnpll_pkg::VCO_SPLIT_HZ)) ? fnpll_pkg::LF_DIV4
                                                         : fnpll_pkg::LF_DIV2;
        r.frac    = fr[23:0];
        r.tuned   = tn[32:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        synth_word_t x;
        if (!rst_n)
        begin
            ref_hz = fnpll_pkg::REF_RESET;
            lo_max = fnpll_pkg::LO_MAX_RESET;
            errors = 0;
            settings_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fnpll_pkg::CFG_REF)
                    ref_hz = cfg_data[fnpll_pkg::REF_W-1:0];
                else if (cfg_index == fnpll_pkg::CFG_LO_MAX)
                    lo_max = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (settings_q.size() == 0)
                begin
                    $display("%0t: unexpected word, got n=%0d err=%0d", $time, n_integer,
                             range_error);
                    errors++;
                end
                else
                begin
                    x = settings_q.pop_front();
                    check_field("n_integer", x.n_int, n_integer);
                    check_field("lo_div_exp", x.div_exp, lo_div_exp);
                    check_field("fbk_code", x.fbk, fbk_code);
                    check_field("loop_filter_code", x.lf, loop_filter_code);
                    check_field("frac_word", x.frac, frac_word);
                    check_field("tuned_freq_hz", x.tuned, tuned_freq_hz);
                    check_field("range_error", x.err, range_error);
                end
            end
            if (in_valid && in_ready)
                settings_q.push_back(calc_settings(lo_req_hz));
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [32:0] lo_req_hz = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  n_integer;
    logic [2:0]  lo_div_exp;
    logic [1:0]  fbk_code;
    logic [1:0]  loop_filter_code;
    logic [23:0] frac_word;
    logic [32:0] tuned_freq_hz;
    logic        range_error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [32:0] cfg_data = '0;
    int          errors;
    int          pending;

    // idle percentages for sender and receiver
    int tx_idle = 0;
    int rx_stall = 0;
    logic [32:0] cur_lo_max = fnpll_pkg::LO_MAX_RESET;

    always #10 clk = ~clk;

    frac_n_pll_divider_calc_core uut (.*);

    fnpll_checker chk (.*);

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_stall);

    task automatic send_request(logic [32:0] lo);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle);
        end
        in_valid  <= 1'b1;
        lo_req_hz <= lo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // write a register once everything in flight has drained
    task automatic write_reg(logic [1:0] idx, logic [32:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == fnpll_pkg::CFG_LO_MAX)
            cur_lo_max = val;
    endtask

    function automatic logic [32:0] pick_lo();
        int sel;
        logic [32:0] r;
        sel = $urandom_range(0, 9);
        r = {1'($urandom), $urandom};
        case (sel)
            0, 1, 2: return (cur_lo_max == 0) ? r : 33'(34'(r) % (34'(cur_lo_max) + 34'd1));
            3:       return cur_lo_max - $urandom_range(0, 3);
            4:       return cur_lo_max + $urandom_range(0, 3);
            5:       return $urandom_range(0, 1000000);
            6:       return (cur_lo_max >> $urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
            7:       return 33'd3200000000 + $urandom_range(0, 4) - 2;
            default: return r;
        endcase
    endfunction

    initial
    begin
        logic [32:0] ref_set[6];
        logic [32:0] max_set[6];
        ref_set = '{33'd26000000, 33'd1000000, 33'd100000000, 33'd0,
                    33'h1FFFFFFFF, 33'd10000000};
        max_set = '{33'd5400000000, 33'd8000000000, 33'd100000000, 33'd5400000000,
                    33'h1FFFFFFFF, 33'd3200000000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                write_reg(fnpll_pkg::CFG_REF, ref_set[p]);
                write_reg(fnpll_pkg::CFG_LO_MAX, max_set[p]);
                // unmapped indexes must be ignored
                write_reg(2'd2 + 2'(p % 2), {1'($urandom), $urandom});
            end
            tx_idle  = (p % 4 == 1) ? 85 : (p % 4 == 3) ? 19 : 0;
            rx_stall = (p % 4 == 2) ? 85 : (p % 4 == 3) ? 19 : 0;
            // boundary requests
            send_request(33'd0);
            send_request(33'd1);
            send_request(cur_lo_max);
            send_request(cur_lo_max + 1);
            send_request(33'h1FFFFFFFF);
            send_request(33'd3200000000);
            send_request(33'd3200000001);
            send_request(cur_lo_max >> 1);
            send_request(cur_lo_max >> 7);
            send_request(cur_lo_max >> 8);
            send_request(33'd1600000001);
            send_request(33'h0AAAAAAAA);
            send_request(33'h155555555);
            for (int i = 0; i < 200; i++)
                send_request(pick_lo());
            in_valid <= 1'b0;
            if (p == 0)
                rx_stall = 0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[frac_n_pll_divider_calc_core] OK");
        else
            $display("[frac_n_pll_divider_calc_core] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[frac_n_pll_divider_calc_core] ERROR");
        $finish;
    end

endmodule

### files.f
src/fnpll_pkg.sv
src/fnpll_front.sv
src/fnpll_queue.sv
src/fnpll_back.sv
src/frac_n_pll_divider_calc_core.sv
dv/fnpll_checker.sv
dv/tb_top.sv
